/* hdl/tks_pkg.sv */
// Shared types and constants for the top-k key selection unit.
// Used by tks_cell and top_k_key_select_unit; depends on nothing else.
package tks_pkg;

  localparam int KEY_W = 32;
  localparam int HALF_W = 16;
  localparam int OUT_IDX_W = 16;
  localparam int KEEP_W = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;
  localparam logic REG_KEEP_COUNT = 1'b0;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic take_prev;
    logic take_next;
  } cell_cmd_t;

endpackage

/* hdl/tks_cell.sv */
// One slot of the sorted insertion chain: a valid bit, a key and an index.
// Depends on tks_pkg for the command struct and key width.
module tks_cell #(
  parameter int IDX_W = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tks_pkg::cell_cmd_t     cmd,
  input  logic [tks_pkg::KEY_W-1:0] new_key,
  input  logic [IDX_W-1:0]       new_idx,
  input  logic                   prev_vld,
  input  logic [tks_pkg::KEY_W-1:0] prev_key,
  input  logic [IDX_W-1:0]       prev_idx,
  input  logic                   next_vld,
  input  logic [tks_pkg::KEY_W-1:0] next_key,
  input  logic [IDX_W-1:0]       next_idx,
  output logic                   vld,
  output logic [tks_pkg::KEY_W-1:0] key,
  output logic [IDX_W-1:0]       idx,
  output logic                   ge
);
  import tks_pkg::*;

  logic             vld_r, vld_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    vld_nxt = vld_r;
    key_nxt = key_r;
    idx_nxt = idx_r;
    if (cmd.clear) begin
      vld_nxt = 1'b0;
    end else if (cmd.insert) begin
      vld_nxt = 1'b1;
      key_nxt = new_key;
      idx_nxt = new_idx;
    end else if (cmd.take_prev) begin
      vld_nxt = prev_vld;
      key_nxt = prev_key;
      idx_nxt = prev_idx;
    end else if (cmd.take_next) begin
      vld_nxt = next_vld;
      key_nxt = next_key;
      idx_nxt = next_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    idx_r <= idx_nxt;
  end

  assign vld = vld_r;
  assign key = key_r;
  assign idx = idx_r;
  assign ge  = vld_r && (key_r >= new_key);

endmodule

/* hdl/top_k_key_select_unit.sv */
// Top level of the top-k key selection unit: chain control, flush drain and APB registers.
// Depends on tks_pkg and tks_cell.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_opcode, in_density_q, in_tie_q
//  out     | output    | out_valid / out_ready| out_cand_index, out_density, out_tie,
//          |           |                      | out_empty_res, out_last
//  cfg     | input     | APB, cfg_pready = 1  | keep_count at byte address 0
//
// On an offer every cell compares its key with the new one in parallel.
// A flush is accepted, then the chain shifts toward cell zero, one result at a time;
// input is held off until the last result is in the output register.
// An empty flush gives a single result.
// Reset is synchronous and active low; no clearing pass is needed after reset.
// A stalled output holds the drain; offers are taken while a result waits.
module top_k_key_select_unit #(
  parameter int MAX_KEEP   = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [0:0]                        in_opcode,
  input  logic [tks_pkg::HALF_W-1:0]        in_density_q,
  input  logic [tks_pkg::HALF_W-1:0]        in_tie_q,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tks_pkg::OUT_IDX_W-1:0]     out_cand_index,
  output logic [tks_pkg::HALF_W-1:0]        out_density,
  output logic [tks_pkg::HALF_W-1:0]        out_tie,
  output logic [0:0]                        out_empty_res,
  output logic [0:0]                        out_last,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tks_pkg::PADDR_W-1:0]       cfg_paddr,
  input  logic [tks_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic [tks_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import tks_pkg::*;

  localparam logic [KEEP_W-1:0] MAX_KEEP_C = KEEP_W'(MAX_KEEP);

  state_t state_r, state_nxt;

  logic [KEEP_W-1:0]     keep_count_r, keep_count_nxt;
  logic [KEEP_W-1:0]     eff_keep, eff_keep_new;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic                  cnt_sat;
  logic                  cfg_wr;
  logic                  in_acc;
  logic                  offer_go;
  logic                  flush_go;
  logic                  drain_shift;
  logic                  out_load;

  logic [KEY_W-1:0]      new_key;
  logic [MAX_KEEP-1:0]   vld;
  logic [MAX_KEEP-1:0]   ge;
  logic [KEY_W-1:0]      key_a [MAX_KEEP];
  logic [INDEX_BITS-1:0] idx_a [MAX_KEEP];
  cell_cmd_t             cmd_a [MAX_KEEP];
  logic                  head_vld;
  logic                  second_vld;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0]  out_idx_r;
  logic [HALF_W-1:0]     out_dens_r;
  logic [HALF_W-1:0]     out_tie_r;
  logic                  out_empty_r;
  logic                  out_last_r;
  logic                  out_last_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[PADDR_W-1] == REG_KEEP_COUNT);
  assign cfg_prdata = (cfg_paddr[PADDR_W-1] == REG_KEEP_COUNT) ?
                      PDATA_W'(keep_count_r) : '0;
  assign keep_count_nxt = cfg_wr ? cfg_pwdata[KEEP_W-1:0] : keep_count_r;
  assign eff_keep = (keep_count_r > MAX_KEEP_C) ? MAX_KEEP_C : keep_count_r;
  assign eff_keep_new = (cfg_pwdata[KEEP_W-1:0] > MAX_KEEP_C) ?
                        MAX_KEEP_C : cfg_pwdata[KEEP_W-1:0];

  assign in_acc   = in_valid && in_ready;
  assign cnt_sat  = &cnt_r;
  assign offer_go = in_acc && (in_opcode[0] == OP_OFFER) && !cnt_sat;
  assign flush_go = in_acc && (in_opcode[0] == OP_FLUSH);
  assign new_key  = {in_density_q, in_tie_q};

  always_comb begin
    cnt_nxt = cnt_r;
    if (flush_go) begin
      cnt_nxt = '0;
    end else if (offer_go) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  genvar i;
  generate
    for (i = 0; i < MAX_KEEP; i++) begin : g_cell
      logic                  prev_ge;
      logic                  in_range;
      logic                  p_vld;
      logic [KEY_W-1:0]      p_key;
      logic [INDEX_BITS-1:0] p_idx;
      logic                  n_vld;
      logic [KEY_W-1:0]      n_key;
      logic [INDEX_BITS-1:0] n_idx;

      if (i == 0) begin : g_first
        assign prev_ge = 1'b1;
        assign p_vld   = 1'b0;
        assign p_key   = '0;
        assign p_idx   = '0;
      end else begin : g_mid
        assign prev_ge = ge[i-1];
        assign p_vld   = vld[i-1];
        assign p_key   = key_a[i-1];
        assign p_idx   = idx_a[i-1];
      end

      if (i == MAX_KEEP - 1) begin : g_tail
        assign n_vld = 1'b0;
        assign n_key = '0;
        assign n_idx = '0;
      end else begin : g_body
        assign n_vld = vld[i+1];
        assign n_key = key_a[i+1];
        assign n_idx = idx_a[i+1];
      end

      assign in_range = KEEP_W'(i) < eff_keep;

      always_comb begin
        cmd_a[i].clear     = cfg_wr && !(KEEP_W'(i) < eff_keep_new);
        cmd_a[i].insert    = offer_go && in_range && !ge[i] && prev_ge;
        cmd_a[i].take_prev = offer_go && in_range && !ge[i] && !prev_ge;
        cmd_a[i].take_next = drain_shift;
      end

      tks_cell #(
        .IDX_W (INDEX_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_a[i]),
        .new_key  (new_key),
        .new_idx  (cnt_r),
        .prev_vld (p_vld),
        .prev_key (p_key),
        .prev_idx (p_idx),
        .next_vld (n_vld),
        .next_key (n_key),
        .next_idx (n_idx),
        .vld      (vld[i]),
        .key      (key_a[i]),
        .idx      (idx_a[i]),
        .ge       (ge[i])
      );
    end

    if (MAX_KEEP > 1) begin : g_second
      assign second_vld = vld[1];
    end else begin : g_single
      assign second_vld = 1'b0;
    end
  endgenerate

  assign head_vld = vld[0];

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    drain_shift = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_opcode[0] == OP_FLUSH)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (head_vld) begin
            drain_shift = 1'b1;
            if (!second_vld) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_last_nxt = !head_vld || !second_vld;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keep_count_r <= KEEP_RESET;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      keep_count_r <= keep_count_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r   <= head_vld ? OUT_IDX_W'(idx_a[0]) : '0;
      out_dens_r  <= head_vld ? key_a[0][KEY_W-1:HALF_W] : '0;
      out_tie_r   <= head_vld ? key_a[0][HALF_W-1:0] : '0;
      out_empty_r <= !head_vld;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cand_index = out_idx_r;
  assign out_density    = out_dens_r;
  assign out_tie        = out_tie_r;
  assign out_empty_res  = out_empty_r;
  assign out_last       = out_last_r;

`ifndef NO_ASSERTIONS
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, vld} + 1'b1))
    else $error("Valid cells do not form a prefix of the chain.");

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld) <= eff_keep)
    else $error("More cells are valid than the keep count allows.");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (vld == '0))
    else $error("The chain is not empty after the last result of a flush.");

  a_flush_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    flush_go |=> (cnt_r == '0))
    else $error("The arrival counter was not cleared by a flush.");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("An empty result is not marked as the last one.");
`endif

endmodule

/* test/tb_top.sv */
// Testbench for top_k_key_select_unit: directed rows, then random offer/flush streams.
// A ranking predictor in the bench supplies the expected items; depends on tks_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tks_pkg::*;

  localparam int SEL_DEPTH = 64;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic [HALF_W-1:0]    dens;
    logic [HALF_W-1:0]    tie;
    logic                 empty;
    logic                 last;
  } sel_result_t;

  typedef struct packed {
    logic              op;
    logic [HALF_W-1:0] dens;
    logic [HALF_W-1:0] tie;
    logic              typed;
    sel_result_t       res;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [0:0]           in_opcode = OP_OFFER;
  logic [HALF_W-1:0]    in_density_q = '0;
  logic [HALF_W-1:0]    in_tie_q = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_IDX_W-1:0] out_cand_index;
  logic [HALF_W-1:0]    out_density;
  logic [HALF_W-1:0]    out_tie;
  logic [0:0]           out_empty_res;
  logic [0:0]           out_last;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]   cfg_paddr = '0;
  logic [PDATA_W-1:0]   cfg_pwdata = '0;
  logic [PDATA_W-1:0]   cfg_prdata;
  logic                 cfg_pready;

  // The typed-in expectation travels with the item so it is sampled at acceptance.
  logic        held_typed = 1'b0;
  sel_result_t held_result = '0;

  logic [31:0]          sel_key [SEL_DEPTH];
  logic [OUT_IDX_W-1:0] sel_idx [SEL_DEPTH];
  int                   sel_len = 0;
  logic [15:0]          arrivals = '0;
  logic [KEEP_W-1:0]    keep_reg = KEEP_RESET;
  sel_result_t          ranked_q [$];

  int mismatches = 0;
  bit idle_on = 1'b1;
  int rdy_hold = 0;

  stim_row_t dir_rows [17] = '{
    '{OP_FLUSH, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1}},
    '{OP_OFFER, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{OP_FLUSH, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}},
    '{OP_OFFER, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_FLUSH, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{OP_OFFER, 16'h1234, 16'h5678, 1'b0, '0},
    '{OP_OFFER, 16'h1234, 16'h5678, 1'b0, '0},
    '{OP_OFFER, 16'h1234, 16'h5679, 1'b0, '0},
    '{OP_OFFER, 16'h0000, 16'hFFFF, 1'b0, '0},
    '{OP_OFFER, 16'hFFFF, 16'h0000, 1'b0, '0},
    '{OP_OFFER, 16'h8000, 16'h0001, 1'b0, '0},
    '{OP_OFFER, 16'h7FFF, 16'hFFFF, 1'b0, '0},
    '{OP_OFFER, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_FLUSH, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_OFFER, 16'hAAAA, 16'h5555, 1'b0, '0},
    '{OP_OFFER, 16'h5555, 16'hAAAA, 1'b0, '0},
    '{OP_FLUSH, 16'h0000, 16'h0000, 1'b0, '0}
  };

  logic [KEEP_W-1:0] keep_plan [9] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd2, 7'd63,
                                       7'd7, 7'd32};

  top_k_key_select_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_density_q(in_density_q),
    .in_tie_q(in_tie_q),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cand_index(out_cand_index),
    .out_density(out_density),
    .out_tie(out_tie),
    .out_empty_res(out_empty_res),
    .out_last(out_last),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int eff_keep();
    return (keep_reg > SEL_DEPTH) ? SEL_DEPTH : int'(keep_reg);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [HALF_W-1:0] pick_half();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(int'($urandom_range(0, 3)));
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic stim_row_t make_row(input logic op);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.dens = pick_half();
    r.tie = pick_half();
    return r;
  endfunction

  function automatic void add_expected(input sel_result_t r);
    ranked_q.insert(ranked_q.size(), r);
  endfunction

  // Ranks one accepted item into the kept list, or drains the list on a flush.
  task automatic rank_item(input logic op, input logic [HALF_W-1:0] d, t);
    int k, n, pos, j;
    logic [31:0] key;
    k = eff_keep();
    if (op == OP_FLUSH) begin
      n = (sel_len < k) ? sel_len : k;
      if (n == 0) add_expected('{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1});
      for (j = 0; j < n; j++) begin
        add_expected('{sel_idx[j], sel_key[j][31:16], sel_key[j][15:0], 1'b0,
                       1'(j == n - 1)});
      end
      sel_len = 0;
      arrivals = '0;
    end else if (arrivals != 16'hFFFF) begin
      key = {d, t};
      pos = 0;
      while (pos < sel_len && sel_key[pos] >= key) pos++;
      if (pos < k) begin
        for (j = (sel_len < k) ? sel_len : k - 1; j > pos; j--) begin
          sel_key[j] = sel_key[j-1];
          sel_idx[j] = sel_idx[j-1];
        end
        sel_key[pos] = key;
        sel_idx[pos] = arrivals;
        if (sel_len < k) sel_len++;
      end
      arrivals++;
    end
  endtask

  task automatic check_field(input string fname, input logic [15:0] want, got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    sel_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        rank_item(in_opcode, in_density_q, in_tie_q);
        if (held_typed) begin
          void'(ranked_q.pop_back());
          add_expected(held_result);
        end
      end
      if (out_valid && out_ready) begin
        if (ranked_q.size() == 0) begin
          $display("%0t ns: item with nothing pending, expected none, got index %h",
                   $time, out_cand_index);
          mismatches++;
        end else begin
          want = ranked_q.pop_front();
          check_field("cand_index", want.idx, out_cand_index);
          check_field("out_density", want.dens, out_density);
          check_field("out_tie", want.tie, out_tie);
          check_field("empty_res", 16'(want.empty), 16'(out_empty_res));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
    end
  end

  always @(posedge clk) begin : ready_gen
    int stall;
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      stall = gap_len();
      out_ready <= (stall == 0);
      rdy_hold <= (stall == 0) ? $urandom_range(0, 7) : stall - 1;
    end
  end

  task automatic send_row(input stim_row_t r);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= r.op;
    in_density_q <= r.dens;
    in_tie_q <= r.tie;
    held_typed <= r.typed;
    held_result <= r.res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {REG_KEEP_COUNT, 2'b00};
    cfg_pwdata <= {$urandom} & ~32'h7F | 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    keep_reg = v;
    if (sel_len > eff_keep()) sel_len = eff_keep();
  endtask

  initial begin
    int rand_items;
    int phase_no;
    int n_off;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // Shrinking the keep count while entries are held must drop the tail at once.
    wait_idle();
    for (int i = 0; i < 30; i++) send_row(make_row(OP_OFFER));
    wait_idle();
    write_keep(7'd4);
    send_row(make_row(OP_FLUSH));

    // Run the arrival counter into saturation; the last offers must be ignored.
    wait_idle();
    write_keep(7'd3);
    idle_on = 1'b0;
    for (int i = 0; i < 65540; i++) begin
      if (i >= 65535) send_row('{OP_OFFER, 16'hFFFF, 16'hFFFF, 1'b0, '0});
      else send_row(make_row(OP_OFFER));
    end
    send_row(make_row(OP_FLUSH));
    send_row(make_row(OP_OFFER));
    send_row(make_row(OP_FLUSH));

    rand_items = 0;
    phase_no = 0;
    while (rand_items < 330) begin
      wait_idle();
      if (phase_no % 10 == 9) write_keep(KEEP_W'($urandom_range(0, 127)));
      else write_keep(keep_plan[phase_no % 10]);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        n_off = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 20);
        for (int i = 0; i < n_off; i++) send_row(make_row(OP_OFFER));
        rand_items += n_off;
        if ($urandom_range(0, 4) != 0) begin
          send_row(make_row(OP_FLUSH));
          rand_items++;
        end
      end
      phase_no++;
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
